@@ sv/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");
// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ sv/crpe_pkg.sv @@
// shared types, widths and helpers of the catmull-rom point evaluator
`default_nettype none
package crpe_pkg;

  // pipeline depth
  localparam int NST = 8;

  // field widths
  localparam int SLOT_W   = 6;
  localparam int COORD_W  = 16;
  localparam int SEG_W    = 6;
  localparam int FRAC_W   = 16;
  localparam int N_W      = 7;
  localparam int ENTRY_W  = 2 * COORD_W;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 32;

  // basis arithmetic widths
  localparam int UU_W  = 2 * FRAC_W;
  localparam int UUU_W = 3 * FRAC_W;
  localparam int T_W   = 52;
  localparam int W_W   = 35;
  localparam int WSUM_W = W_W + 2;

  // blend arithmetic widths
  localparam int PROD_W    = COORD_W + W_W;
  localparam int SUM_W     = 54;
  localparam int SHIFT_OUT = 33;
  localparam int Q_W       = SUM_W - SHIFT_OUT;
  localparam int MOD_W     = N_W + SEG_W;

  // fixed-point constants
  localparam logic signed [T_W-1:0]    W1_CONST   = T_W'(64'h2_0000_0000);
  localparam logic signed [WSUM_W-1:0] WSUM_ONE   = WSUM_W'(64'h2_0000_0000);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(64'h1_0000_0000);
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [Q_W-1:0]     SAT_HI    = Q_W'(COORD_MAX);
  localparam logic signed [Q_W-1:0]     SAT_LO    = Q_W'(COORD_MIN);

  // item kind carried in tuser
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  // configuration register indexes
  typedef enum logic {
    REG_LOOP_MODE   = 1'b0,
    REG_POINT_COUNT = 1'b1
  } cfg_reg_t;

  // per-stage advance
  typedef struct packed {
    logic [NST:1] en;
  } pipe_ctl_t;

  // one compare-subtract step of a remainder by n shifted left k
  function automatic logic [SEG_W-1:0] mod_step(input logic [SEG_W-1:0] r,
                                                input logic [N_W-1:0] n,
                                                input int unsigned k);
    logic [MOD_W-1:0] d;
    d = MOD_W'(n) << k;
    if (MOD_W'(r) >= d) begin
      mod_step = r - d[SEG_W-1:0];
    end else begin
      mod_step = r;
    end
  endfunction

  // clamp to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [Q_W-1:0] v);
    if (v > SAT_HI) begin
      sat16 = COORD_MAX;
    end else if (v < SAT_LO) begin
      sat16 = COORD_MIN;
    end else begin
      sat16 = v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/crpe_ram.sv @@
// generic single-write, single-read ram with registered read
`default_nettype none
module crpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/crpe_addr.sv @@
// point index pipeline: segment remainder, four table indices, range flag
`default_nettype none
module crpe_addr #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                                clk,
  input  wire crpe_pkg::pipe_ctl_t                 ctl,
  input  wire crpe_pkg::action_t                   in_action,
  input  wire logic [crpe_pkg::SLOT_W-1:0]         in_slot,
  input  wire logic signed [crpe_pkg::COORD_W-1:0] in_x,
  input  wire logic signed [crpe_pkg::COORD_W-1:0] in_y,
  input  wire logic [crpe_pkg::SEG_W-1:0]          in_seg,
  input  wire logic                                loop_mode,
  input  wire logic [crpe_pkg::N_W-1:0]            n_eff,
  output crpe_pkg::action_t                        action4,
  output logic [crpe_pkg::SLOT_W-1:0]              slot4,
  output logic signed [crpe_pkg::COORD_W-1:0]      x4,
  output logic signed [crpe_pkg::COORD_W-1:0]      y4,
  output logic [3:0][$clog2(MAX_POINTS)-1:0]       idx4,
  output logic                                     oor4
);
  import crpe_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  action_t                    act1, act2, act3;
  logic [SLOT_W-1:0]          slot1, slot2, slot3;
  logic signed [COORD_W-1:0]  x1, x2, x3, y1, y2, y3;
  logic [SEG_W-1:0]           seg1, seg2, seg3;
  logic [SEG_W-1:0]           r1, r2, r3;
  logic [N_W-1:0]             p, sg, t2, t3;
  logic [3:0][N_W-1:0]        ic;
  logic                       oor_c;

  // stage 1 to 3: remainder of segment by point count, two steps a stage
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      act1  <= in_action;
      slot1 <= in_slot;
      x1    <= in_x;
      y1    <= in_y;
      seg1  <= in_seg;
      r1    <= mod_step(mod_step(in_seg, n_eff, 5), n_eff, 4);
    end
    if (ctl.en[2]) begin
      act2  <= act1;
      slot2 <= slot1;
      x2    <= x1;
      y2    <= y1;
      seg2  <= seg1;
      r2    <= mod_step(mod_step(r1, n_eff, 3), n_eff, 2);
    end
    if (ctl.en[3]) begin
      act3  <= act2;
      slot3 <= slot2;
      x3    <= x2;
      y3    <= y2;
      seg3  <= seg2;
      r3    <= mod_step(mod_step(r2, n_eff, 1), n_eff, 0);
    end
  end

  // index selection for closed and open curves
  always_comb begin
    p  = N_W'(r3);
    sg = N_W'(seg3);
    t2 = p + 7'd1;
    t3 = p + 7'd2;
    if (loop_mode) begin
      ic[0] = (p == '0) ? n_eff - 7'd1 : p - 7'd1;
      ic[1] = p;
      ic[2] = (t2 >= n_eff) ? '0 : t2;
      if (n_eff == 7'd1) begin
        ic[3] = '0;
      end else begin
        ic[3] = (t3 >= n_eff) ? t3 - n_eff : t3;
      end
      oor_c = 1'b0;
    end else begin
      ic[0] = sg;
      ic[1] = sg + 7'd1;
      ic[2] = sg + 7'd2;
      ic[3] = sg + 7'd3;
      oor_c = (sg + 7'd3) >= n_eff;
    end
  end

  // stage 4: table addresses
  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      action4 <= act3;
      slot4   <= slot3;
      x4      <= x3;
      y4      <= y3;
      oor4    <= oor_c;
      for (int k = 0; k < 4; k++) begin
        idx4[k] <= AW'(ic[k]);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/crpe_basis.sv @@
// cubic basis weight pipeline from the fraction of t
`default_nettype none
module crpe_basis (
  input  wire logic                         clk,
  input  wire crpe_pkg::pipe_ctl_t          ctl,
  input  wire logic [crpe_pkg::FRAC_W-1:0]  u_in,
  output logic [3:0][crpe_pkg::W_W-1:0]     w5
);
  import crpe_pkg::*;

  logic [FRAC_W-1:0]       u1, u2;
  logic [UU_W-1:0]         uu1, uu2;
  logic [UUU_W-1:0]        uuu2;
  logic signed [T_W-1:0]   c, uq, us;
  logic signed [T_W-1:0]   wt0, wt1, wt2, wt3;
  logic [3:0][W_W-1:0]     w3, w4, w_c;

  // weights: floor of the cubic term plus exact lower terms
  always_comb begin
    c   = T_W'(uuu2);
    uq  = T_W'(uu2);
    us  = T_W'(u2);
    wt0 = ((-c) >>> 16) + (uq <<< 1) - (us <<< 16);
    wt1 = (((c <<< 1) + c) >>> 16) - (uq <<< 2) - uq + W1_CONST;
    wt2 = ((-(c <<< 1) - c) >>> 16) + (uq <<< 2) + (us <<< 16);
    wt3 = (c >>> 16) - uq;
    w_c[0] = wt0[W_W-1:0];
    w_c[1] = wt1[W_W-1:0];
    w_c[2] = wt2[W_W-1:0];
    w_c[3] = wt3[W_W-1:0];
  end

  // stage 1 square, stage 2 cube, stage 3 weights, stages 4 and 5 align
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      u1  <= u_in;
      uu1 <= u_in * u_in;
    end
    if (ctl.en[2]) begin
      u2   <= u1;
      uu2  <= uu1;
      uuu2 <= uu1 * u1;
    end
    if (ctl.en[3]) begin
      w3 <= w_c;
    end
    if (ctl.en[4]) begin
      w4 <= w3;
    end
    if (ctl.en[5]) begin
      w5 <= w4;
    end
  end

endmodule
`default_nettype wire

@@ sv/crpe_blend.sv @@
// weighted blend of four points, rounding and saturation
`default_nettype none
module crpe_blend (
  input  wire logic                                 clk,
  input  wire crpe_pkg::pipe_ctl_t                  ctl,
  input  wire logic [3:0][crpe_pkg::ENTRY_W-1:0]    pts5,
  input  wire logic [3:0][crpe_pkg::W_W-1:0]        w5,
  input  wire logic                                 oor5,
  output logic signed [crpe_pkg::COORD_W-1:0]       x8,
  output logic signed [crpe_pkg::COORD_W-1:0]       y8,
  output logic                                      oor8
);
  import crpe_pkg::*;

  logic signed [PROD_W-1:0] px6 [4];
  logic signed [PROD_W-1:0] py6 [4];
  logic signed [SUM_W-1:0]  sum_x, sum_y, sx7, sy7;
  logic                     oor6, oor7;

  // four-term sums with the half added for rounding
  always_comb begin
    sum_x = ROUND_HALF;
    sum_y = ROUND_HALF;
    for (int k = 0; k < 4; k++) begin
      sum_x = sum_x + SUM_W'(px6[k]);
      sum_y = sum_y + SUM_W'(py6[k]);
    end
  end

  // stage 6 products, stage 7 sums, stage 8 round and saturate
  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      oor6 <= oor5;
      for (int k = 0; k < 4; k++) begin
        px6[k] <= $signed(pts5[k][ENTRY_W-1:COORD_W]) * $signed(w5[k]);
        py6[k] <= $signed(pts5[k][COORD_W-1:0]) * $signed(w5[k]);
      end
    end
    if (ctl.en[7]) begin
      oor7 <= oor6;
      sx7  <= sum_x;
      sy7  <= sum_y;
    end
    if (ctl.en[8]) begin
      oor8 <= oor7;
      x8   <= oor7 ? '0 : sat16(sx7[SUM_W-1:SHIFT_OUT]);
      y8   <= oor7 ? '0 : sat16(sy7[SUM_W-1:SHIFT_OUT]);
    end
  end

endmodule
`default_nettype wire

@@ sv/catmull_rom_point_eval_top.sv @@
// top level of the catmull-rom point evaluator
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: action; tdata: index, x, y, t
//   m_*      out  m_tvalid/m_tready  tuser: out_of_range; tdata: curve x, y
//   cfg_*    in   cfg_valid/ready    cfg_index: register, cfg_data: value
//
// one beat per cycle in both directions while m_tready is high; a result
// leaves through the eight register stages of the pipeline.
// a point write lands in the table at stage 5, in order with evaluations.
// reset clears the stage valid bits and the configuration registers; the
// point table keeps no reset and must be written before it is read.
// each stage holds while its successor is full and blocked; bubbles fill.
`default_nettype none
`include "assert_macros.svh"
module catmull_rom_point_eval_top #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [5:0] point_index, [21:6] point_x, [37:22] point_y, [59:38] t_pos
  input  wire logic [crpe_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] action
  input  wire logic [0:0]                         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [15:0] curve_x, [31:16] curve_y
  output logic [crpe_pkg::M_TDATA_W-1:0]          m_tdata,
  // [0] out_of_range
  output logic [0:0]                              m_tuser,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire crpe_pkg::cfg_reg_t                 cfg_index,
  input  wire logic [crpe_pkg::N_W-1:0]           cfg_data
);
  import crpe_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int N_CAP = (MAX_POINTS < 127) ? MAX_POINTS : 127;
  localparam logic [N_W-1:0] N_CAP_V = N_W'(N_CAP);

  logic                      loop_mode;
  logic [N_W-1:0]            point_count;
  logic [N_W-1:0]            n_eff;
  logic [NST:1]              en, vld, vld_next;
  pipe_ctl_t                 ctl;
  action_t                   action4, eval5;
  logic [SLOT_W-1:0]         slot4;
  logic signed [COORD_W-1:0] x4, y4, x8, y8;
  logic [3:0][AW-1:0]        idx4;
  logic                      oor4, oor5, oor8;
  logic                      wr_en;
  logic [3:0][ENTRY_W-1:0]   rd_pts;
  logic [3:0][W_W-1:0]       w5;
  logic signed [WSUM_W-1:0]  w_sum;
  logic                      rd_used;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode   <= 1'b0;
      point_count <= N_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOOP_MODE:   loop_mode   <= cfg_data[0];
        REG_POINT_COUNT: point_count <= cfg_data;
      endcase
    end
  end

  // point count in use, held between one and the table size, capped at 127
  always_comb begin
    if (point_count == '0) begin
      n_eff = N_W'(1);
    end else if (point_count > N_CAP_V) begin
      n_eff = N_CAP_V;
    end else begin
      n_eff = point_count;
    end
  end

  // stage advance chain from the output back to the input
  always_comb begin
    en[NST] = !vld[NST] || m_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // stage valid bits; point writes leave the pipe after the table stage
  always_comb begin
    vld_next = vld;
    for (int k = 1; k <= NST; k++) begin
      if (en[k]) begin
        if (k == 1) begin
          vld_next[k] = s_tvalid;
        end else if (k == 6) begin
          vld_next[k] = vld[5] && (eval5 == ACT_EVAL);
        end else begin
          vld_next[k] = vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ctl.en   = en;
  assign s_tready = en[1];

  // index path
  crpe_addr #(
    .MAX_POINTS(MAX_POINTS)
  ) u_addr (
    .clk       (clk),
    .ctl       (ctl),
    .in_action (action_t'(s_tuser[0])),
    .in_slot   (s_tdata[5:0]),
    .in_x      (s_tdata[21:6]),
    .in_y      (s_tdata[37:22]),
    .in_seg    (s_tdata[59:54]),
    .loop_mode (loop_mode),
    .n_eff     (n_eff),
    .action4   (action4),
    .slot4     (slot4),
    .x4        (x4),
    .y4        (y4),
    .idx4      (idx4),
    .oor4      (oor4)
  );

  // weight path
  crpe_basis u_basis (
    .clk  (clk),
    .ctl  (ctl),
    .u_in (s_tdata[53:38]),
    .w5   (w5)
  );

  // table stage: writes and the four point reads share this step
  assign wr_en = en[5] && vld[4] && (action4 == ACT_WRITE) && (int'(slot4) < MAX_POINTS);

  for (genvar g = 0; g < 4; g++) begin : g_tbl
    crpe_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_POINTS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (AW'(slot4)),
      .wr_data ({x4, y4}),
      .rd_en   (en[5]),
      .rd_addr (idx4[g]),
      .rd_data (rd_pts[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      eval5 <= action4;
      oor5  <= oor4;
    end
  end

  // blend and output register
  crpe_blend u_blend (
    .clk  (clk),
    .ctl  (ctl),
    .pts5 (rd_pts),
    .w5   (w5),
    .oor5 (oor5),
    .x8   (x8),
    .y8   (y8),
    .oor8 (oor8)
  );

  assign m_tvalid = vld[NST];
  assign m_tdata  = {y8, x8};
  assign m_tuser  = oor8;

  // weight total for the checks below
  always_comb begin
    w_sum = '0;
    for (int k = 0; k < 4; k++) begin
      w_sum = w_sum + WSUM_W'($signed(w5[k]));
    end
  end

  // table stage holds an in-range evaluation whose read data is used
  assign rd_used = vld[5] && (eval5 == ACT_EVAL) && !oor5;

  // an out-of-range result carries zero coordinates
  `ASSERT_IMPLY(a_oor_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0)
  // a blocked table stage keeps its item and its read data
  `ASSERT_NEXT(a_rd_hold, clk, rst, rd_used && !en[6], vld[5] && $stable(rd_pts))
  // basis weights sum to one within the flooring error
  `ASSERT_IMPLY(a_w_sum, clk, rst, vld[5], (w_sum <= WSUM_ONE) && (w_sum >= WSUM_ONE - 2))

endmodule
`default_nettype wire
